>>> src/bact_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bact_pkg;

    // Character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Scope codes kept on the stack
    typedef logic [1:0] scope_code_t;
    localparam scope_code_t SC_PAREN = 2'd0;
    localparam scope_code_t SC_BRACE = 2'd1;
    localparam scope_code_t SC_BRACK = 2'd2;
    localparam scope_code_t SC_NONE  = 2'd3;

    // Line status codes
    typedef logic [2:0] status_t;
    localparam status_t STAT_OK       = 3'd0;
    localparam status_t STAT_MISMATCH = 3'd1;
    localparam status_t STAT_UNCLOSED = 3'd2;
    localparam status_t STAT_TOO_LONG = 3'd3;
    localparam status_t STAT_OVERFLOW = 3'd4;

    // Result item kinds
    localparam logic KIND_TOKEN  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        TK_IDLE,
        TK_PROC,
        TK_TRIM,
        TK_TOKEN,
        TK_STATUS
    } tok_state_t;

    typedef enum logic [1:0] {
        TR_IDLE,
        TR_REQ,
        TR_EVAL,
        TR_DONE
    } trim_state_t;

    typedef enum logic [2:0] {
        STEP_OPEN0,
        STEP_OPEN1,
        STEP_OPEN2,
        STEP_LSEP,
        STEP_TSEP,
        STEP_QUOTE
    } trim_step_t;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    endfunction

    function automatic scope_code_t opener_code(input logic [7:0] c);
        scope_code_t code;
        case (c)
            CH_LPAREN: code = SC_PAREN;
            CH_LBRACE: code = SC_BRACE;
            CH_LBRACK: code = SC_BRACK;
            default:   code = SC_NONE;
        endcase
        return code;
    endfunction

    function automatic scope_code_t closer_code(input logic [7:0] c);
        scope_code_t code;
        case (c)
            CH_RPAREN: code = SC_PAREN;
            CH_RBRACE: code = SC_BRACE;
            CH_RBRACK: code = SC_BRACK;
            default:   code = SC_NONE;
        endcase
        return code;
    endfunction

    // Opener checked at each of the three leading-bracket steps
    function automatic logic [7:0] step_opener(input trim_step_t step);
        logic [7:0] c;
        case (step)
            STEP_OPEN0: c = CH_LPAREN;
            STEP_OPEN1: c = CH_LBRACE;
            default:    c = CH_LBRACK;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

>>> src/bact_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/bact_trim.sv
`timescale 1ns / 1ps
`default_nettype none
module bact_trim #(
    parameter int LINE_MAX = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [$clog2(LINE_MAX+1)-1:0] start_pos,
    input  wire logic [$clog2(LINE_MAX+1)-1:0] start_len,
    output logic      [$clog2(LINE_MAX)-1:0]   rd_addr,
    input  wire logic [7:0]                    rd_data,
    output logic                               done,
    output logic      [$clog2(LINE_MAX+1)-1:0] res_pos,
    output logic      [$clog2(LINE_MAX+1)-1:0] res_len
);
    import bact_pkg::*;

    localparam int PW = $clog2(LINE_MAX + 1);
    localparam int AW = $clog2(LINE_MAX);

    trim_state_t       state_reg, state_next;
    trim_step_t        step_reg, step_next;
    logic              changed_reg, changed_next;
    logic [PW-1:0]     s_reg, s_next;
    logic [PW-1:0]     n_reg, n_next;
    logic [PW-1:0]     last_pos;
    logic [PW-1:0]     n_m1;
    logic [PW-1:0]     n_m2;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= TR_IDLE;
            step_reg    <= STEP_OPEN0;
            changed_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            changed_reg <= changed_next;
        end
    end

    // Span registers
    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        n_reg <= n_next;
    end

    assign last_pos = s_reg + n_reg - PW'(1);
    assign n_m1     = n_reg - PW'(1);
    assign n_m2     = (n_m1 != '0) ? n_reg - PW'(2) : '0;

    // Read the front character, or the back one for the trailing check
    assign rd_addr = (step_reg == STEP_TSEP) ? last_pos[AW-1:0] : s_reg[AW-1:0];

    // Step through the checks, one line store read per check
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        changed_next = changed_reg;
        s_next       = s_reg;
        n_next       = n_reg;
        case (state_reg)
            TR_IDLE:
            begin
                if (start)
                begin
                    s_next       = start_pos;
                    n_next       = start_len;
                    step_next    = STEP_OPEN0;
                    changed_next = 1'b1;
                    state_next   = TR_REQ;
                end
            end
            TR_REQ:
            begin
                if (n_reg == '0)
                begin
                    state_next = TR_DONE;
                end
                else if (step_reg == STEP_OPEN0 && !changed_reg)
                begin
                    state_next = TR_DONE;
                end
                else
                begin
                    if (step_reg == STEP_OPEN0)
                    begin
                        changed_next = 1'b0;
                    end
                    state_next = TR_EVAL;
                end
            end
            TR_EVAL:
            begin
                state_next = TR_REQ;
                case (step_reg)
                    STEP_OPEN0, STEP_OPEN1, STEP_OPEN2:
                    begin
                        if (rd_data == step_opener(step_reg))
                        begin
                            s_next       = s_reg + PW'(1);
                            n_next       = n_m2;
                            changed_next = 1'b1;
                        end
                        case (step_reg)
                            STEP_OPEN0: step_next = STEP_OPEN1;
                            STEP_OPEN1: step_next = STEP_OPEN2;
                            default:    step_next = STEP_LSEP;
                        endcase
                    end
                    STEP_LSEP:
                    begin
                        if (is_sep(rd_data))
                        begin
                            s_next       = s_reg + PW'(1);
                            n_next       = n_m1;
                            changed_next = 1'b1;
                        end
                        step_next = STEP_TSEP;
                    end
                    STEP_TSEP:
                    begin
                        if (is_sep(rd_data))
                        begin
                            n_next       = n_m1;
                            changed_next = 1'b1;
                        end
                        step_next = STEP_QUOTE;
                    end
                    STEP_QUOTE:
                    begin
                        if (rd_data == CH_QUOTE)
                        begin
                            s_next     = s_reg + PW'(1);
                            n_next     = n_m2;
                            state_next = TR_DONE;
                        end
                        else
                        begin
                            step_next = STEP_OPEN0;
                        end
                    end
                    default:
                    begin
                        state_next = TR_DONE;
                    end
                endcase
            end
            TR_DONE:
            begin
                state_next = TR_IDLE;
            end
            default:
            begin
                state_next = TR_IDLE;
            end
        endcase
    end

    assign done    = (state_reg == TR_DONE);
    assign res_pos = s_reg;
    assign res_len = n_reg;

endmodule
`default_nettype wire

>>> src/bracket_aware_command_tokenizer.sv
// Command-line tokenizer with quote and bracket awareness.
// Input channel (in_valid/in_ready) carries one byte of the line per item,
// with end_of_line set on its last byte. Output channel (out_valid/out_ready)
// carries token spans (item_kind 0: token_start, token_length) and, once per
// line, a status item (item_kind 1, status_code, final_item set).
// An ordinary byte is handled by reading the top of the scope stack memory
// and then updating the line state. A byte that closes a token adds the
// trim: a line store read and an evaluation per check (one line store read
// each), up to six checks per pass, before the item is handed over.
// The end of a line adds a status item.
// The line bytes sit in a LINE_MAX-byte memory and the scope stack in a
// SCOPE_DEPTH-entry memory; neither is cleared, and no entry is read before
// it is written on the same line. Reset clears the line state and the output
// register; the block takes a byte right after reset.
// A stalled receiver holds the result in the output register; the next byte
// is still accepted, and the block waits only when it has another result
// to hand over.
`timescale 1ns / 1ps
`default_nettype none
module bracket_aware_command_tokenizer #(
    parameter int LINE_MAX    = 256,
    parameter int SCOPE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_char,
    input  wire logic        end_of_line,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             item_kind,
    output logic [7:0]       token_start,
    output logic [8:0]       token_length,
    output logic [2:0]       status_code,
    output logic             final_item
);
    import bact_pkg::*;

    localparam int PW  = $clog2(LINE_MAX + 1);
    localparam int AW  = $clog2(LINE_MAX);
    localparam int DW  = $clog2(SCOPE_DEPTH + 1);
    localparam int SAW = $clog2(SCOPE_DEPTH);
    localparam logic [PW-1:0] LINE_LIMIT  = PW'(LINE_MAX);
    localparam logic [DW-1:0] SCOPE_LIMIT = DW'(SCOPE_DEPTH);

    tok_state_t      state_reg, state_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [PW-1:0]   pts_reg, pts_next;
    logic            quote_reg, quote_next;
    logic [DW-1:0]   depth_reg, depth_next;
    status_t         err_reg, err_next;
    logic [7:0]      char_reg, char_next;
    logic            eol_reg, eol_next;

    logic            out_valid_reg, out_valid_next;
    logic            kind_reg, kind_next;
    logic [7:0]      start_reg, start_next;
    logic [8:0]      len_reg, len_next;
    status_t         status_reg, status_next;
    logic            final_reg, final_next;

    logic            line_we;
    logic [AW-1:0]   line_raddr;
    logic [7:0]      line_rdata;
    logic            stack_we;
    logic [SAW-1:0]  stack_waddr;
    scope_code_t     stack_wdata;
    logic [SAW-1:0]  stack_raddr;
    scope_code_t     stack_rdata;
    logic [DW-1:0]   depth_m1;

    logic            trim_start;
    logic [PW-1:0]   tok_pos;
    logic [PW-1:0]   tok_len;
    logic            trim_done;
    logic [PW-1:0]   trim_pos;
    logic [PW-1:0]   trim_len;

    logic            out_free;
    logic            sep;
    scope_code_t     oc;
    scope_code_t     cc;

    // Line byte store
    bact_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (pos_reg[AW-1:0]),
        .wdata (in_char),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Scope stack store
    bact_ram #(
        .WIDTH (2),
        .DEPTH (SCOPE_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // Token trim sequencer
    bact_trim #(
        .LINE_MAX (LINE_MAX)
    ) u_trim (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (trim_start),
        .start_pos (tok_pos),
        .start_len (tok_len),
        .rd_addr   (line_raddr),
        .rd_data   (line_rdata),
        .done      (trim_done),
        .res_pos   (trim_pos),
        .res_len   (trim_len)
    );

    // Control and line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TK_IDLE;
            pos_reg       <= '0;
            pts_reg       <= '0;
            quote_reg     <= 1'b0;
            depth_reg     <= '0;
            err_reg       <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            pts_reg       <= pts_next;
            quote_reg     <= quote_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        eol_reg    <= eol_next;
        kind_reg   <= kind_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
        status_reg <= status_next;
        final_reg  <= final_next;
    end

    // Read the stack top while waiting for a byte
    assign depth_m1    = depth_reg - DW'(1);
    assign stack_raddr = depth_m1[SAW-1:0];
    assign stack_waddr = depth_reg[SAW-1:0];

    assign out_free = !out_valid_reg || out_ready;
    assign sep      = is_sep(char_reg);
    assign oc       = opener_code(char_reg);
    assign cc       = closer_code(char_reg);

    // Next state, line update and result loading
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        pts_next       = pts_reg;
        quote_next     = quote_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        char_next      = char_reg;
        eol_next       = eol_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        status_next    = status_reg;
        final_next     = final_reg;
        in_ready       = 1'b0;
        line_we        = 1'b0;
        stack_we       = 1'b0;
        stack_wdata    = oc;
        trim_start     = 1'b0;
        tok_pos        = pts_reg;
        tok_len        = pos_reg - pts_reg;
        case (state_reg)
            TK_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    char_next  = in_char;
                    eol_next   = end_of_line;
                    line_we    = (pos_reg < LINE_LIMIT);
                    state_next = TK_PROC;
                end
            end
            TK_PROC:
            begin
                if (pos_reg < LINE_LIMIT)
                begin
                    pos_next = pos_reg + PW'(1);
                    if (sep && pts_reg == pos_reg)
                    begin
                        // skip a separator at the token start
                        pts_next = pos_reg + PW'(1);
                    end
                    else if (sep && !quote_reg && depth_reg == '0)
                    begin
                        // close the token before this separator
                        trim_start = 1'b1;
                        tok_pos    = pts_reg;
                        tok_len    = pos_reg - pts_reg;
                        pts_next   = pos_reg + PW'(1);
                    end
                    else if (char_reg == CH_QUOTE)
                    begin
                        quote_next = !quote_reg;
                    end
                    else if (!quote_reg)
                    begin
                        if (oc != SC_NONE)
                        begin
                            if (depth_reg < SCOPE_LIMIT)
                            begin
                                stack_we   = 1'b1;
                                depth_next = depth_reg + DW'(1);
                            end
                            else if (err_reg == STAT_OK)
                            begin
                                err_next = STAT_OVERFLOW;
                            end
                        end
                        else if (cc != SC_NONE)
                        begin
                            if (depth_reg == '0 || stack_rdata != cc)
                            begin
                                if (err_reg == STAT_OK)
                                begin
                                    err_next = STAT_MISMATCH;
                                end
                            end
                            else
                            begin
                                depth_next = depth_m1;
                            end
                        end
                    end
                end
                else if (err_reg == STAT_OK)
                begin
                    err_next = STAT_TOO_LONG;
                end
                // final token of the line
                if (!trim_start && eol_reg && pts_next < pos_next)
                begin
                    trim_start = 1'b1;
                    tok_pos    = pts_next;
                    tok_len    = pos_next - pts_next;
                end
                if (trim_start)
                begin
                    state_next = TK_TRIM;
                end
                else if (eol_reg)
                begin
                    state_next = TK_STATUS;
                end
                else
                begin
                    state_next = TK_IDLE;
                end
            end
            TK_TRIM:
            begin
                if (trim_done)
                begin
                    state_next = TK_TOKEN;
                end
            end
            TK_TOKEN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TOKEN;
                    start_next     = 8'(trim_pos);
                    len_next       = 9'(trim_len);
                    status_next    = STAT_OK;
                    final_next     = 1'b0;
                    state_next     = eol_reg ? TK_STATUS : TK_IDLE;
                end
            end
            TK_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STATUS;
                    start_next     = '0;
                    len_next       = '0;
                    final_next     = 1'b1;
                    if (err_reg != STAT_OK)
                    begin
                        status_next = err_reg;
                    end
                    else if (quote_reg || depth_reg != '0)
                    begin
                        status_next = STAT_UNCLOSED;
                    end
                    else
                    begin
                        status_next = STAT_OK;
                    end
                    // drop the line state
                    pos_next   = '0;
                    pts_next   = '0;
                    quote_next = 1'b0;
                    depth_next = '0;
                    err_next   = STAT_OK;
                    state_next = TK_IDLE;
                end
            end
            default:
            begin
                state_next = TK_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign item_kind    = kind_reg;
    assign token_start  = start_reg;
    assign token_length = len_reg;
    assign status_code  = status_reg;
    assign final_item   = final_reg;

endmodule
`default_nettype wire
